>>> rtl/core/pngargb_pkg.sv
// ----------------------------------------------------------------------------
// pngargb_pkg
// Shared types, constants and helper functions for the scanline to ARGB
// converter.
// ----------------------------------------------------------------------------
package pngargb_pkg;

    localparam int PAL_ENTRIES = 256;
    localparam int ENTRY_W     = $clog2(PAL_ENTRIES);

    localparam logic [9:0]  PAL_BYTES  = 10'd768;
    localparam logic [12:0] MAX_WIDTH  = 13'd4096;
    localparam logic [12:0] LINE_LIMIT = 13'd4096;
    localparam logic [31:0] OPAQUE     = 32'hFF00_0000;

    localparam logic OP_SCANLINE = 1'b0;
    localparam logic OP_PALETTE  = 1'b1;

    localparam logic [1:0] CFG_COLOR_MODE = 2'd0;
    localparam logic [1:0] CFG_LINE_WIDTH = 2'd1;
    localparam logic [1:0] CFG_LINE_COUNT = 2'd2;

    localparam logic [1:0] LANE_RED   = 2'd0;
    localparam logic [1:0] LANE_GREEN = 2'd1;

    typedef enum logic [2:0] {
        CM_GREY       = 3'd0,
        CM_RGB        = 3'd2,
        CM_PALETTE    = 3'd3,
        CM_GREY_ALPHA = 3'd4,
        CM_RGBA       = 3'd6
    } color_mode_t;

    typedef struct packed {
        logic [2:0]  color_mode;
        logic [12:0] line_width;
        logic [12:0] line_count;
    } cfg_t;

    typedef struct packed {
        logic        emit;
        logic        pal_mode;
        logic        eol;
        logic        eof;
        logic [31:0] argb;
    } asm_out_t;

    typedef struct packed {
        logic               en;
        logic [ENTRY_W-1:0] entry;
        logic [1:0]         lane;
        logic [7:0]         data;
    } pal_wr_t;

    function automatic logic [2:0] bytes_for_mode(input logic [2:0] mode);
        case (mode)
            CM_RGB:        bytes_for_mode = 3'd3;
            CM_RGBA:       bytes_for_mode = 3'd4;
            CM_GREY_ALPHA: bytes_for_mode = 3'd2;
            default:       bytes_for_mode = 3'd1;
        endcase
    endfunction

    function automatic logic [12:0] clamp_count(input logic [12:0] v,
                                                input logic [12:0] limit);
        if (v == 13'd0) begin
            clamp_count = 13'd1;
        end else if (v > limit) begin
            clamp_count = limit;
        end else begin
            clamp_count = v;
        end
    endfunction

    // byte address / 3 via reciprocal multiply, exact below 768
    function automatic logic [ENTRY_W-1:0] pal_entry(input logic [9:0] addr);
        logic [19:0] prod;
        prod      = {10'd0, addr} * 20'd683;
        pal_entry = prod[18:11];
    endfunction

    function automatic logic [1:0] pal_lane(input logic [9:0] addr);
        logic [9:0] base;
        base     = {2'b00, pal_entry(addr)} * 10'd3;
        pal_lane = 2'(addr - base);
    endfunction

    function automatic logic [23:0] lane_merge(input logic [23:0] word,
                                               input logic [1:0]  lane,
                                               input logic [7:0]  data);
        case (lane)
            LANE_RED:   lane_merge = {data, word[15:0]};
            LANE_GREEN: lane_merge = {word[23:16], data, word[7:0]};
            default:    lane_merge = {word[23:8], data};
        endcase
    endfunction

    function automatic logic [31:0] make_pixel(input logic [2:0]  mode,
                                               input logic [23:0] held,
                                               input logic [7:0]  c);
        case (mode)
            CM_GREY:       make_pixel = {8'hFF, c, c, c};
            CM_RGB:        make_pixel = {8'hFF, held[15:0], c};
            CM_GREY_ALPHA: make_pixel = {c, held[7:0], held[7:0], held[7:0]};
            CM_RGBA:       make_pixel = {c, held};
            default:       make_pixel = OPAQUE;
        endcase
    endfunction

endpackage

>>> rtl/core/pngargb_palette.sv
// ----------------------------------------------------------------------------
// pngargb_palette
// Palette store: 256 x 24 synchronous memory with per-entry valid bits,
// byte-lane read-modify-write and write-to-read forwarding.
// ----------------------------------------------------------------------------
module pngargb_palette (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              rd_en,
    input  logic [pngargb_pkg::ENTRY_W-1:0]   rd_addr,
    input  pngargb_pkg::pal_wr_t              wr,
    output logic [23:0]                       rd_word
);
    import pngargb_pkg::*;

    logic [23:0]          mem [PAL_ENTRIES];
    logic [PAL_ENTRIES-1:0] valid_reg;
    logic [23:0]          rd_data_reg;
    logic                 rd_valid_reg;
    logic [ENTRY_W-1:0]   rd_addr_reg;
    logic                 fwd_valid_reg;
    logic [ENTRY_W-1:0]   fwd_addr_reg;
    logic [23:0]          fwd_data_reg;
    logic [23:0]          wr_word;
    logic                 fwd_hit;

    assign fwd_hit = fwd_valid_reg && (fwd_addr_reg == rd_addr_reg);
    assign rd_word = fwd_hit ? fwd_data_reg : (rd_valid_reg ? rd_data_reg : 24'd0);
    assign wr_word = lane_merge(rd_word, wr.lane, wr.data);

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.entry] <= wr_word;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
            rd_addr_reg <= rd_addr;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg     <= '0;
            rd_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
            fwd_addr_reg  <= '0;
            fwd_data_reg  <= '0;
        end else begin
            if (wr.en) begin
                valid_reg[wr.entry] <= 1'b1;
                fwd_valid_reg       <= 1'b1;
                fwd_addr_reg        <= wr.entry;
                fwd_data_reg        <= wr_word;
            end
            if (rd_en) begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

endmodule

>>> rtl/core/pngargb_assembler.sv
// ----------------------------------------------------------------------------
// pngargb_assembler
// Pixel assembly from scanline bytes: filter byte skip, byte gathering,
// column and row counting with line and frame end flags.
// ----------------------------------------------------------------------------
module pngargb_assembler (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  fire,
    input  logic [7:0]            data_byte,
    input  pngargb_pkg::cfg_t     cfg,
    output pngargb_pkg::asm_out_t result
);
    import pngargb_pkg::*;

    logic [2:0]  byte_in_pixel_reg, byte_in_pixel_next;
    logic [23:0] held_reg, held_next;
    logic        expect_filter_reg, expect_filter_next;
    logic [11:0] column_reg, column_next;
    logic [11:0] row_reg, row_next;

    logic [2:0]  bpp;
    logic        more;
    logic [12:0] width;
    logic [12:0] lines;
    logic        eol;
    logic        eof;

    always_comb begin
        bpp   = bytes_for_mode(cfg.color_mode);
        more  = (({1'b0, byte_in_pixel_reg} + 4'd1) < {1'b0, bpp});
        width = clamp_count(cfg.line_width, MAX_WIDTH);
        lines = clamp_count(cfg.line_count, LINE_LIMIT);
        eol   = (({1'b0, column_reg} + 13'd1) >= width);
        eof   = eol && (({1'b0, row_reg} + 13'd1) >= lines);

        result.emit     = !expect_filter_reg && !more;
        result.pal_mode = (cfg.color_mode == CM_PALETTE);
        result.eol      = eol;
        result.eof      = eof;
        result.argb     = make_pixel(cfg.color_mode, held_reg, data_byte);

        byte_in_pixel_next = byte_in_pixel_reg;
        held_next          = held_reg;
        expect_filter_next = expect_filter_reg;
        column_next        = column_reg;
        row_next           = row_reg;

        if (fire) begin
            if (expect_filter_reg) begin
                expect_filter_next = 1'b0;
            end else if (more) begin
                held_next          = {held_reg[15:0], data_byte};
                byte_in_pixel_next = byte_in_pixel_reg + 3'd1;
            end else begin
                byte_in_pixel_next = 3'd0;
                held_next          = 24'd0;
                if (eol) begin
                    column_next        = 12'd0;
                    expect_filter_next = 1'b1;
                    row_next           = eof ? 12'd0 : row_reg + 12'd1;
                end else begin
                    column_next = column_reg + 12'd1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_in_pixel_reg <= 3'd0;
            held_reg          <= 24'd0;
            expect_filter_reg <= 1'b1;
            column_reg        <= 12'd0;
            row_reg           <= 12'd0;
        end else begin
            byte_in_pixel_reg <= byte_in_pixel_next;
            held_reg          <= held_next;
            expect_filter_reg <= expect_filter_next;
            column_reg        <= column_next;
            row_reg           <= row_next;
        end
    end

endmodule

>>> rtl/core/png_scanline_to_argb_converter.sv
// ----------------------------------------------------------------------------
// png_scanline_to_argb_converter
// 8-bit PNG scanline bytes to ARGB8888 pixels, with palette store.
// Input passes the lookup stage register, then the output register, to m_.
// Throughput: one input transaction per cycle unless a pixel waits behind a
//   stalled output; limited by the single palette memory port pair (one read and one write each cycle).
// Reset: synchronous, active low; clears counters and palette valid bits, sets
//   config to grey with line width and line count 1; no clearing pass.
// ----------------------------------------------------------------------------
module png_scanline_to_argb_converter (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [12:0] cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_operation,
    input  logic [7:0]  s_data_byte,
    input  logic [9:0]  s_palette_addr,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_argb,
    output logic        m_end_of_line,
    output logic        m_end_of_frame
);
    import pngargb_pkg::*;

    cfg_t     cfg_reg;
    asm_out_t asm_res;
    pal_wr_t  pal_wr;
    logic     palette_loaded_reg;

    logic     accept;
    logic     scan_fire;
    logic     wr_in_range;
    logic     s1_load;
    logic     s1_go;
    logic [ENTRY_W-1:0] rd_addr;
    logic [23:0] pal_word;

    logic               s1_valid_reg, s1_valid_next;
    logic               s1_is_wr_reg;
    logic               s1_pal_reg;
    logic [ENTRY_W-1:0] s1_entry_reg;
    logic [1:0]         s1_lane_reg;
    logic [7:0]         s1_byte_reg;
    logic [31:0]        s1_argb_reg;
    logic               s1_eol_reg;
    logic               s1_eof_reg;

    logic               m_valid_reg, m_valid_next;
    logic [31:0]        m_argb_reg;
    logic               m_eol_reg;
    logic               m_eof_reg;

    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.color_mode <= CM_GREY;
            cfg_reg.line_width <= 13'd1;
            cfg_reg.line_count <= 13'd1;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_COLOR_MODE: cfg_reg.color_mode <= cfg_wdata[2:0];
                CFG_LINE_WIDTH: cfg_reg.line_width <= cfg_wdata;
                CFG_LINE_COUNT: cfg_reg.line_count <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign s1_go   = s1_is_wr_reg || !m_valid_reg || m_ready;
    assign s_ready = !s1_valid_reg || s1_go;
    assign accept  = s_valid && s_ready;

    assign scan_fire   = accept && (s_operation == OP_SCANLINE);
    assign wr_in_range = (s_palette_addr < PAL_BYTES);
    assign s1_load     = accept && ((s_operation == OP_PALETTE) ? wr_in_range : asm_res.emit);
    assign rd_addr     = (s_operation == OP_PALETTE) ? pal_entry(s_palette_addr) : s_data_byte;

    pngargb_assembler u_asm (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .fire      (scan_fire),
        .data_byte (s_data_byte),
        .cfg       (cfg_reg),
        .result    (asm_res)
    );

    always_comb begin
        pal_wr.en    = s1_valid_reg && s1_is_wr_reg;
        pal_wr.entry = s1_entry_reg;
        pal_wr.lane  = s1_lane_reg;
        pal_wr.data  = s1_byte_reg;
    end

    pngargb_palette u_pal (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (accept),
        .rd_addr (rd_addr),
        .wr      (pal_wr),
        .rd_word (pal_word)
    );

    // lookup stage
    always_comb begin
        if (s1_load) begin
            s1_valid_next = 1'b1;
        end else if (s1_go) begin
            s1_valid_next = 1'b0;
        end else begin
            s1_valid_next = s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg       <= 1'b0;
            s1_is_wr_reg       <= 1'b0;
            palette_loaded_reg <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            if (s1_load) begin
                s1_is_wr_reg <= (s_operation == OP_PALETTE);
            end
            if (accept && (s_operation == OP_PALETTE) && wr_in_range) begin
                palette_loaded_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_load) begin
            s1_pal_reg   <= asm_res.pal_mode && palette_loaded_reg;
            s1_entry_reg <= pal_entry(s_palette_addr);
            s1_lane_reg  <= pal_lane(s_palette_addr);
            s1_byte_reg  <= s_data_byte;
            s1_argb_reg  <= asm_res.argb;
            s1_eol_reg   <= asm_res.eol;
            s1_eof_reg   <= asm_res.eof;
        end
    end

    // output register
    always_comb begin
        if (s1_valid_reg && !s1_is_wr_reg && s1_go) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_valid_reg && !s1_is_wr_reg && s1_go) begin
            m_argb_reg <= s1_pal_reg ? (OPAQUE | {8'h00, pal_word}) : s1_argb_reg;
            m_eol_reg  <= s1_eol_reg;
            m_eof_reg  <= s1_eof_reg;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_argb         = m_argb_reg;
    assign m_end_of_line  = m_eol_reg;
    assign m_end_of_frame = m_eof_reg;

    // palette write in the lookup stage never blocks the input
    a_wr_no_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && s1_is_wr_reg) |-> s_ready)
        else $error("palette write stage stalled the input");

    // pending pixel behind a stalled output holds off new transactions
    a_pixel_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && !s1_is_wr_reg && m_valid_reg && !m_ready) |-> !s_ready)
        else $error("transaction accepted over a blocked pixel");

    // frame end only on a line end
    a_eof_on_eol: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (!m_end_of_frame || m_end_of_line))
        else $error("frame end without line end");

    // palette present flag is sticky until reset
    a_loaded_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        palette_loaded_reg |=> palette_loaded_reg)
        else $error("palette present flag dropped");

endmodule

>>> bench/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Checks the scanline to ARGB converter: palette loads, every colour mode,
// skipped filter bytes, line and frame flags and geometry clamping, against an
// in-bench pixel predictor. A short directed stimulus list is followed by
// randomized phases with bursty input and a stalling output channel.
// ----------------------------------------------------------------------------
module tb;
    import pngargb_pkg::*;

    localparam int RUN_LIMIT = 200000;
    localparam int ITEMS     = 450;
    localparam int PHASES    = 10;
    localparam int SETTLE    = 4;
    localparam int HOLD_OFF  = 200;

    localparam logic [2:0] CM_UNKNOWN_5 = 3'd5;

    typedef struct packed {
        logic [31:0] argb;
        logic        eol;
        logic        eof;
    } pixel_t;

    typedef struct packed {
        logic        is_cfg;
        logic        op;
        logic [7:0]  data;
        logic [9:0]  addr;
        logic        typed;
        pixel_t      px;
        logic [2:0]  mode;
        logic [12:0] width;
        logic [12:0] lines;
    } stim_row_t;

    logic        aclk;
    logic        aresetn        = 1'b0;
    logic        cfg_wr_en      = 1'b0;
    logic [1:0]  cfg_index      = CFG_COLOR_MODE;
    logic [12:0] cfg_wdata      = '0;
    logic        s_valid        = 1'b0;
    logic        s_ready;
    logic        s_operation    = OP_SCANLINE;
    logic [7:0]  s_data_byte    = '0;
    logic [9:0]  s_palette_addr = '0;
    logic        m_valid;
    logic        m_ready        = 1'b0;
    logic [31:0] m_argb;
    logic        m_end_of_line;
    logic        m_end_of_frame;

    png_scanline_to_argb_converter DUT (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_operation    (s_operation),
        .s_data_byte    (s_data_byte),
        .s_palette_addr (s_palette_addr),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_argb         (m_argb),
        .m_end_of_line  (m_end_of_line),
        .m_end_of_frame (m_end_of_frame)
    );

    // predictor state
    logic [2:0]  cur_mode;
    logic [12:0] cur_width;
    logic [12:0] cur_lines;
    logic [23:0] pal_mem [PAL_ENTRIES];
    logic        pal_present;
    int          bytes_in;
    logic [23:0] held;
    logic        want_filter;
    int          col;
    int          row;

    pixel_t      pending_pixels[$];
    stim_row_t   stim_rows[$];
    pixel_t      want;

    int mismatches     = 0;
    int items_sent     = 0;
    int pixels_checked = 0;
    int palette_writes = 0;
    int line_ends      = 0;
    int frame_ends     = 0;
    int burst_left     = 0;
    bit hold_req       = 1'b0;

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    initial begin
        repeat (RUN_LIMIT) @(posedge aclk);
        $display("tb: done, errors");
        $finish;
    end

    function automatic int pixel_size(input logic [2:0] mode);
        case (mode)
            CM_RGB:        return 3;
            CM_RGBA:       return 4;
            CM_GREY_ALPHA: return 2;
            default:       return 1;
        endcase
    endfunction

    task automatic convert_item(input logic op, input logic [7:0] c, input logic [9:0] addr,
                                output logic got, output pixel_t px);
        int          w;
        int          n;
        int          entry;
        logic [1:0]  lane;
        logic [7:0]  g;
        got = 1'b0;
        px  = '0;
        if (op == OP_PALETTE) begin
            if (addr < PAL_BYTES) begin
                entry = addr / 3;
                lane  = 2'(addr % 3);
                case (lane)
                    LANE_RED:   pal_mem[entry][23:16] = c;
                    LANE_GREEN: pal_mem[entry][15:8]  = c;
                    default:    pal_mem[entry][7:0]   = c;
                endcase
                pal_present = 1'b1;
                palette_writes++;
            end
        end else if (want_filter) begin
            want_filter = 1'b0;
        end else if (bytes_in + 1 < pixel_size(cur_mode)) begin
            held = {held[15:0], c};
            bytes_in++;
        end else begin
            w = (cur_width == 0) ? 1 : (cur_width > MAX_WIDTH) ? int'(MAX_WIDTH) : cur_width;
            n = (cur_lines == 0) ? 1 : (cur_lines > LINE_LIMIT) ? int'(LINE_LIMIT) : cur_lines;
            g = held[7:0];
            case (cur_mode)
                CM_GREY:       px.argb = {8'hFF, c, c, c};
                CM_RGB:        px.argb = {8'hFF, held[15:0], c};
                CM_PALETTE:    px.argb = pal_present ? {8'hFF, pal_mem[c]} : OPAQUE;
                CM_GREY_ALPHA: px.argb = {c, g, g, g};
                CM_RGBA:       px.argb = {c, held};
                default:       px.argb = OPAQUE;
            endcase
            px.eol   = (col + 1 >= w);
            px.eof   = px.eol && (row + 1 >= n);
            bytes_in = 0;
            held     = '0;
            if (px.eol) begin
                col         = 0;
                want_filter = 1'b1;
                row         = px.eof ? 0 : row + 1;
            end else begin
                col++;
            end
            got = 1'b1;
        end
    endtask

    task automatic send_item(input logic op, input logic [7:0] data, input logic [9:0] addr);
        s_valid        <= 1'b1;
        s_operation    <= op;
        s_data_byte    <= data;
        s_palette_addr <= addr;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
    endtask

    // let all pending pixels drain, plus a settling wait for items with no pixel
    task automatic drain();
        s_valid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic set_config(input logic [2:0] mode, input logic [12:0] w,
                              input logic [12:0] n);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_COLOR_MODE;
        cfg_wdata <= {10'd0, mode};
        @(posedge aclk);
        cfg_index <= CFG_LINE_WIDTH;
        cfg_wdata <= w;
        @(posedge aclk);
        cfg_index <= CFG_LINE_COUNT;
        cfg_wdata <= n;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        cur_mode  = mode;
        cur_width = w;
        cur_lines = n;
    endtask

    task automatic pace(input bit steady);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap        = steady ? 0 : $urandom_range(0, 7);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
    endtask

    task automatic add_cfg(input logic [2:0] mode, input logic [12:0] w, input logic [12:0] n);
        stim_row_t r;
        r        = '0;
        r.is_cfg = 1'b1;
        r.mode   = mode;
        r.width  = w;
        r.lines  = n;
        stim_rows.push_back(r);
    endtask

    task automatic add_item(input logic op, input logic [7:0] data, input logic [9:0] addr);
        stim_row_t r;
        r      = '0;
        r.op   = op;
        r.data = data;
        r.addr = addr;
        stim_rows.push_back(r);
    endtask

    task automatic add_pixel(input logic [7:0] data, input logic [31:0] argb,
                             input logic eol, input logic eof);
        stim_row_t r;
        r       = '0;
        r.op    = OP_SCANLINE;
        r.data  = data;
        r.typed = 1'b1;
        r.px    = {argb, eol, eof};
        stim_rows.push_back(r);
    endtask

    // output channel: random stall patterns, one long hold-off on request
    initial begin : receiver
        int cyc;
        int pattern;
        int hold_left;
        bit hold_done;
        cyc       = 0;
        pattern   = 0;
        hold_left = 0;
        hold_done = 1'b0;
        forever begin
            @(posedge aclk);
            cyc++;
            if (cyc % 97 == 0) pattern = $urandom_range(0, 3);
            if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                hold_left = HOLD_OFF;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                case (pattern)
                    0:       m_ready <= 1'b1;
                    1:       m_ready <= 1'($urandom_range(0, 1));
                    2:       m_ready <= (cyc % 4 == 0);
                    default: m_ready <= ($urandom_range(0, 4) != 0);
                endcase
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_pixels.size() == 0) begin
                $display("%0t: unexpected pixel %08h eol %0b eof %0b", $time,
                         m_argb, m_end_of_line, m_end_of_frame);
                mismatches++;
            end else begin
                want = pending_pixels.pop_front();
                if (m_argb !== want.argb) begin
                    $display("%0t: argb expected %08h, got %08h", $time, want.argb, m_argb);
                    mismatches++;
                end
                if (m_end_of_line !== want.eol) begin
                    $display("%0t: end_of_line expected %0b, got %0b", $time,
                             want.eol, m_end_of_line);
                    mismatches++;
                end
                if (m_end_of_frame !== want.eof) begin
                    $display("%0t: end_of_frame expected %0b, got %0b", $time,
                             want.eof, m_end_of_frame);
                    mismatches++;
                end
                pixels_checked++;
                if (want.eol) line_ends++;
                if (want.eof) frame_ends++;
            end
        end
    end

    initial begin : stimulus
        logic        got;
        pixel_t      px;
        stim_row_t   r;
        logic        op;
        logic [7:0]  data;
        logic [9:0]  addr;
        logic [2:0]  mode;
        logic [12:0] w;
        logic [12:0] n;
        int          counted;
        int          roll;
        bit          steady;

        cur_mode    = CM_GREY;
        cur_width   = 13'd1;
        cur_lines   = 13'd1;
        pal_present = 1'b0;
        bytes_in    = 0;
        held        = '0;
        want_filter = 1'b1;
        col         = 0;
        row         = 0;
        foreach (pal_mem[i]) pal_mem[i] = '0;

        // reset geometry, grey
        add_item(OP_SCANLINE, 8'h00, 10'd0);
        add_pixel(8'hFF, 32'hFFFF_FFFF, 1'b1, 1'b1);
        // palette mode before any palette write
        add_cfg(CM_PALETTE, 13'd2, 13'd2);
        add_item(OP_SCANLINE, 8'h00, 10'd0);
        add_pixel(8'hFF, OPAQUE, 1'b0, 1'b0);
        add_pixel(8'h00, OPAQUE, 1'b1, 1'b0);
        // last valid address, two out of range, first address
        add_item(OP_PALETTE, 8'hAB, 10'd767);
        add_item(OP_PALETTE, 8'hCD, 10'd768);
        add_item(OP_PALETTE, 8'hEF, 10'd1023);
        add_item(OP_PALETTE, 8'h12, 10'd0);
        add_item(OP_SCANLINE, 8'h00, 10'd0);
        add_item(OP_SCANLINE, 8'hFF, 10'd0);
        add_item(OP_SCANLINE, 8'h00, 10'd0);
        // unknown mode, zero geometry
        add_cfg(CM_UNKNOWN_5, 13'd0, 13'd0);
        add_item(OP_SCANLINE, 8'h00, 10'd0);
        add_pixel(8'h3C, OPAQUE, 1'b1, 1'b1);
        // oversized geometry, palette write inside an rgba pixel
        add_cfg(CM_RGBA, 13'h1FFF, 13'h1FFF);
        add_item(OP_SCANLINE, 8'h00, 10'd0);
        add_item(OP_SCANLINE, 8'h11, 10'd0);
        add_item(OP_PALETTE, 8'h34, 10'd1);
        add_item(OP_SCANLINE, 8'h22, 10'd0);
        add_item(OP_SCANLINE, 8'h33, 10'd0);
        add_item(OP_SCANLINE, 8'h80, 10'd0);
        // width shrinks below the current column, mode changes mid-line
        add_cfg(CM_GREY_ALPHA, 13'd1, LINE_LIMIT);
        add_item(OP_SCANLINE, 8'h40, 10'd0);
        add_item(OP_SCANLINE, 8'hC0, 10'd0);
        add_cfg(CM_RGB, 13'd1, 13'd1);
        add_item(OP_SCANLINE, 8'h00, 10'd0);
        add_item(OP_SCANLINE, 8'h01, 10'd0);
        add_item(OP_SCANLINE, 8'h02, 10'd0);
        add_item(OP_SCANLINE, 8'h03, 10'd0);

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (stim_rows[i]) begin
            r = stim_rows[i];
            if (r.is_cfg) begin
                drain();
                set_config(r.mode, r.width, r.lines);
            end else begin
                send_item(r.op, r.data, r.addr);
                convert_item(r.op, r.data, r.addr, got, px);
                if (got) pending_pixels.push_back(r.typed ? r.px : px);
            end
        end

        for (int phase = 0; phase < PHASES; phase++) begin
            drain();
            mode = (phase < 8) ? 3'(phase) : 3'($urandom_range(0, 7));
            case (phase)
                0:       w = 13'h1FFF;
                1:       w = MAX_WIDTH;
                2:       w = 13'd0;
                default: w = 13'($urandom_range(1, 5));
            endcase
            case (phase)
                3:       n = 13'h1FFF;
                4:       n = LINE_LIMIT;
                5:       n = 13'd0;
                default: n = 13'($urandom_range(1, 4));
            endcase
            set_config(mode, w, n);
            if (phase == 4) hold_req = 1'b1;
            steady  = (phase == 6);
            counted = 0;
            while (counted < ITEMS / PHASES) begin
                roll = $urandom_range(0, 99);
                if (roll < 12) begin
                    op   = OP_PALETTE;
                    addr = ($urandom_range(0, 7) == 0) ? 10'($urandom_range(768, 1023))
                                                       : 10'($urandom_range(0, 767));
                end else begin
                    op   = OP_SCANLINE;
                    addr = 10'($urandom_range(0, 1023));
                end
                data = 8'($urandom_range(0, 255));
                pace(steady);
                send_item(op, data, addr);
                convert_item(op, data, addr, got, px);
                if (got) pending_pixels.push_back(px);
                if (!(op == OP_PALETTE && addr >= PAL_BYTES)) counted++;
            end
        end

        drain();
        repeat (8) @(posedge aclk);

        $display("tb: %0d input transactions, %0d palette writes, %0d pixels checked",
                 items_sent, palette_writes, pixels_checked);
        $display("tb: %0d line ends, %0d frame ends, all eight colour modes",
                 line_ends, frame_ends);
        if (mismatches == 0 && pending_pixels.size() == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

endmodule
